### src/json_string_unescape_core_defines.svh
// ----------------------------------------------------------------------------
// json_string_unescape_core_defines
// Assertion macros shared by the string unescape core. They expand to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define JSU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define JSU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and helpers for the JSON string unescape core.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

   // capacity register reset value
   localparam logic [15:0] CAP_RESET = 16'd8192;

   // character codes
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DIG0   = 8'h30;
   localparam logic [7:0] CH_DIG9   = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   // utf-8 encoding constants
   localparam logic [15:0] UTF_ONE_LIMIT = 16'h0080;
   localparam logic [15:0] UTF_TWO_LIMIT = 16'h0800;
   localparam logic [7:0]  UTF_LEAD2     = 8'hC0;
   localparam logic [7:0]  UTF_LEAD3     = 8'hE0;
   localparam logic [7:0]  UTF_CONT      = 8'h80;
   localparam logic [5:0]  UTF_CONT_MASK = 6'h3F;

   // decoder mode
   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_BODY = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_HEX0 = 3'd3,
      MODE_HEX1 = 3'd4,
      MODE_HEX2 = 3'd5,
      MODE_HEX3 = 3'd6
   } mode_type;

   // result kind
   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] len;
   } result_type;

   // all results caused by one input word, item 0 goes out first
   typedef struct packed {
      logic [1:0]             count;
      result_type [2:0]       item;
   } bundle_type;

   // hex digit decode: bit 4 is valid, bits 3:0 the value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] t;
      logic [4:0] r;
      t = 8'h00;
      r = 5'h00;
      case (c) inside
         [CH_DIG0:CH_DIG9]: begin
            t = c - CH_DIG0;
            r = {1'b1, t[3:0]};
         end
         [CH_LOW_A:CH_LOW_F]: begin
            t = c - CH_LOW_A + 8'd10;
            r = {1'b1, t[3:0]};
         end
         [CH_UP_A:CH_UP_F]: begin
            t = c - CH_UP_A + 8'd10;
            r = {1'b1, t[3:0]};
         end
         default: r = 5'h00;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

### src/json_string_unescape_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Streaming decoder for one JSON string literal: handles the escapes \" \\ \/
// \n \r \t and \uXXXX (to UTF-8), reports done with the length, or an error.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_in_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_kind, rsp_data_byte,
//                                            rsp_decoded_length, rsp_last
//   csr      in         csr_wr_en            csr_wr_data (output capacity)
//
// One input byte per cycle while req_stall is low. A byte goes input register
// -> decoder -> result register, which hands its results out in order.
// The final hex digit of a \u escape yields up to three words out of the one
// result register, holding req until the last of them is taken.
// Opening quote, backslashes, u and first three hex digits give no result.
// Reset is synchronous; the capacity register returns to 8192.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_core import jsu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_decoded_length,
   output logic             rsp_last,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic [15:0] cap_ff;
   logic        emit_ready;
   logic        advance;
   bundle_type  bundle;

   // decode the held byte once the result register can take its bundle
   assign advance   = in_valid_ff && emit_ready;
   assign req_stall = in_valid_ff && !advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // output capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   jsu_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_byte  (in_byte_ff),
      .capacity (cap_ff),
      .bundle   (bundle)
   );

   jsu_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .load               (advance),
      .bundle_in          (bundle),
      .ready              (emit_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_decoded_length (rsp_decoded_length),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

### src/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Escape decoder state machine. Consumes one byte per advance and produces
// the bundle of up to three results that the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_decode import jsu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic [7:0]  in_byte,
   input  wire logic [15:0] capacity,
   output bundle_type       bundle
);

   mode_type    mode_ff, mode_in;
   logic [15:0] code_ff, code_in;
   logic [15:0] count_ff, count_in;

   logic [15:0] cnt1, cnt2, cnt3;
   logic [16:0] room_sum;
   logic        cap_full;
   logic [4:0]  hex;
   logic [15:0] code_val;

   assign cnt1     = count_ff + 16'd1;
   assign cnt2     = count_ff + 16'd2;
   assign cnt3     = count_ff + 16'd3;
   assign room_sum = {1'b0, count_ff} + 17'd3;
   assign cap_full = room_sum >= {1'b0, capacity};
   assign hex      = hex_digit(in_byte);
   assign code_val = {code_ff[11:0], hex[3:0]};

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         code_ff  <= '0;
         count_ff <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         code_ff  <= code_in;
         count_ff <= count_in;
      end
   end

   // next state and results
   always_comb begin
      logic       esc_ok;
      logic [7:0] esc_val;
      logic       fin;
      kind_type   fin_kind;
      mode_in  = mode_ff;
      code_in  = code_ff;
      count_in = count_ff;
      bundle   = '0;
      esc_ok   = 1'b0;
      esc_val  = CH_NUL;
      fin      = 1'b0;
      fin_kind = KIND_ERROR;

      case (mode_ff)
         MODE_IDLE: begin
            if (in_byte == CH_QUOTE) begin
               mode_in  = MODE_BODY;
               code_in  = '0;
               count_in = '0;
            end else begin
               fin = 1'b1;
            end
         end
         MODE_BODY: begin
            if (in_byte == CH_NUL) begin
               fin = 1'b1;
            end else if (in_byte == CH_QUOTE) begin
               fin      = 1'b1;
               fin_kind = KIND_DONE;
            end else if (cap_full) begin
               fin = 1'b1;
            end else if (in_byte == CH_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               bundle.count   = 2'd1;
               bundle.item[0] = '{kind: KIND_DATA, data: in_byte, len: cnt1};
               count_in       = cnt1;
            end
         end
         MODE_ESC: begin
            case (in_byte)
               CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                  esc_ok  = 1'b1;
                  esc_val = in_byte;
               end
               CH_LOW_N: begin
                  esc_ok  = 1'b1;
                  esc_val = CH_LF;
               end
               CH_LOW_R: begin
                  esc_ok  = 1'b1;
                  esc_val = CH_CR;
               end
               CH_LOW_T: begin
                  esc_ok  = 1'b1;
                  esc_val = CH_TAB;
               end
               default: esc_ok = 1'b0;
            endcase
            if (esc_ok) begin
               bundle.count   = 2'd1;
               bundle.item[0] = '{kind: KIND_DATA, data: esc_val, len: cnt1};
               count_in       = cnt1;
               mode_in        = MODE_BODY;
            end else if (in_byte == CH_LOW_U) begin
               code_in = '0;
               mode_in = MODE_HEX0;
            end else begin
               fin = 1'b1;
            end
         end
         MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
            if (!hex[4]) begin
               fin = 1'b1;
            end else begin
               code_in = code_val;
               case (mode_ff)
                  MODE_HEX0: mode_in = MODE_HEX1;
                  MODE_HEX1: mode_in = MODE_HEX2;
                  default:   mode_in = MODE_HEX3;
               endcase
            end
         end
         MODE_HEX3: begin
            if (!hex[4]) begin
               fin = 1'b1;
            end else begin
               // utf-8 encode the gathered code unit
               if (code_val < UTF_ONE_LIMIT) begin
                  bundle.count   = 2'd1;
                  bundle.item[0] = '{kind: KIND_DATA, data: code_val[7:0], len: cnt1};
                  count_in       = cnt1;
               end else if (code_val < UTF_TWO_LIMIT) begin
                  bundle.count   = 2'd2;
                  bundle.item[0] = '{kind: KIND_DATA,
                                     data: UTF_LEAD2 | {3'b000, code_val[10:6]},
                                     len: cnt1};
                  bundle.item[1] = '{kind: KIND_DATA,
                                     data: UTF_CONT | {2'b00, code_val[5:0] & UTF_CONT_MASK},
                                     len: cnt2};
                  count_in       = cnt2;
               end else begin
                  bundle.count   = 2'd3;
                  bundle.item[0] = '{kind: KIND_DATA,
                                     data: UTF_LEAD3 | {4'h0, code_val[15:12]},
                                     len: cnt1};
                  bundle.item[1] = '{kind: KIND_DATA,
                                     data: UTF_CONT | {2'b00, code_val[11:6] & UTF_CONT_MASK},
                                     len: cnt2};
                  bundle.item[2] = '{kind: KIND_DATA,
                                     data: UTF_CONT | {2'b00, code_val[5:0] & UTF_CONT_MASK},
                                     len: cnt3};
                  count_in       = cnt3;
               end
               code_in = '0;
               mode_in = MODE_BODY;
            end
         end
         default: begin
            fin = 1'b1;
         end
      endcase

      // done or error closes the string
      if (fin) begin
         bundle.count   = 2'd1;
         bundle.item[0] = '{kind: fin_kind, data: 8'h00, len: count_ff};
         mode_in        = MODE_IDLE;
         code_in        = '0;
         count_in       = '0;
      end
   end

endmodule

`default_nettype wire

### src/jsu_emit.sv
// ----------------------------------------------------------------------------
// jsu_emit
// Result register. Holds the bundle of one input word and hands its
// results out one word per cycle on the response channel while rsp_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "json_string_unescape_core_defines.svh"

module jsu_emit import jsu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire bundle_type  bundle_in,
   output logic             ready,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_decoded_length,
   output logic             rsp_last
);

   result_type [2:0] slot_ff, slot_in;
   logic [1:0]       rem_ff, rem_in;
   logic             pop;

   assign rsp_valid = rem_ff != 2'd0;
   assign pop       = rsp_valid && !rsp_stall;
   // free once empty or when the last pending word leaves now
   assign ready     = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && pop);

   // load a new bundle or shift out the word just taken
   always_comb begin
      slot_in = slot_ff;
      rem_in  = rem_ff;
      if (load) begin
         slot_in = bundle_in.item;
         rem_in  = bundle_in.count;
      end else if (pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         rem_in     = rem_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign rsp_kind           = slot_ff[0].kind;
   assign rsp_data_byte      = slot_ff[0].data;
   assign rsp_decoded_length = slot_ff[0].len;
   assign rsp_last           = rem_ff == 2'd1;

   // a done or error word always closes its bundle
   `JSU_ASSERT_NOW(a_final_closes, clock, reset,
      rsp_valid && (slot_ff[0].kind != KIND_DATA), rsp_last, "done/error word not last")

   // a non-empty bundle shows its first word in the next cycle
   `JSU_ASSERT_NEXT(a_load_shows, clock, reset,
      load && (bundle_in.count != 2'd0), rsp_valid && (slot_ff[0] == $past(bundle_in.item[0])),
      "loaded bundle not presented")

   // taking a word of a longer bundle leaves one fewer pending
   `JSU_ASSERT_NEXT(a_pop_counts, clock, reset,
      pop && !load && (rem_ff > 2'd1), rem_ff == ($past(rem_ff) - 2'd1),
      "pending count lost a word")

endmodule

`default_nettype wire
